// ----- rtl/core/dasch_pkg.sv -----
package dasch_pkg;

  localparam int unsigned SLOTS     = 8;
  localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned DIV_W     = 26;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [31:0]      WINDOW_MS = 32'd60000;
  localparam logic [DIV_W-1:0] MS_PER_S  = DIV_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SPACING    = 3'd0,
    CFG_MAX_PER_MINUTE = 3'd1,
    CFG_BELT_SPEED     = 3'd2,
    CFG_DIST_ONE       = 3'd3,
    CFG_DIST_TWO       = 3'd4,
    CFG_DIST_THREE     = 3'd5,
    CFG_ADVANCE        = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_PASS       = 3'd1,
    ST_INVALID    = 3'd2,
    ST_THROUGHPUT = 3'd3,
    ST_FULL       = 3'd4
  } sched_status_e;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_TICK     = 1'b1
  } op_e;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic scan_step;
    logic sched_commit;
    logic tick_commit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_op;
    logic div_busy;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/dasch_divider.sv -----
module dasch_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dasch_pkg::DIV_W-1:0] dividend_i,
  input  logic [dasch_pkg::CFG_W-1:0] divisor_i,
  output logic                        busy_o,
  output logic [dasch_pkg::DIV_W-1:0] quotient_o
);
  import dasch_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CFG_W-1:0]     rem_q, rem_d;
  logic [CFG_W-1:0]     dsr_q, dsr_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [CFG_W:0]       trial;
  logic                 ge;

  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    ge     = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W);
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? CFG_W'(trial - {1'b0, dsr_q}) : trial[CFG_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/dasch_datapath.sv -----
module dasch_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dasch_pkg::ctrl_cmd_t            cmd_i,
  output dasch_pkg::dp_status_t           status_o,
  input  logic                            cfg_we_i,
  input  logic [dasch_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dasch_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                            operation_i,
  input  logic [31:0]                     time_ms_i,
  input  logic [1:0]                      target_pos_i,
  input  logic [15:0]                     event_id_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      sched_status_o,
  output logic [31:0]                     due_ms_o,
  output logic                            fired_o,
  output logic [1:0]                      fired_pos_o,
  output logic [15:0]                     fired_event_id_o,
  output logic [31:0]                     last_due_out_o
);
  import dasch_pkg::*;

  logic [15:0] min_sp_q, speed_q, dist1_q, dist2_q, dist3_q, adv_q;
  logic [7:0]  max_q;

  logic [31:0] time_q;
  logic [1:0]  pos_q;
  logic [15:0] evt_q;

  logic [31:0] slot_due_q [SLOTS];
  logic [1:0]  slot_tgt_q [SLOTS];
  logic [15:0] slot_evt_q [SLOTS];
  logic [SLOTS-1:0] slot_valid_q;

  logic [31:0] last_fire_q, last_due_q, win_start_q;
  logic [7:0]  win_cnt_q;

  logic [SLOT_W-1:0] scan_idx_q, best_idx_q;
  logic              best_found_q;
  logic [31:0]       best_due_q;
  logic [1:0]        best_tgt_q;
  logic [15:0]       best_evt_q;

  logic [2:0]  res_status_q;
  logic [31:0] res_due_q, res_last_q;
  logic        res_fired_q;
  logic [1:0]  res_pos_q;
  logic [15:0] res_evt_q;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [31:0] out_due_q, out_last_q;
  logic        out_fired_q;
  logic [1:0]  out_pos_q;
  logic [15:0] out_evt_q;

  logic [15:0]       dist_sel;
  logic [DIV_W-1:0]  dividend;
  logic [DIV_W-1:0]  quotient;
  logic              div_busy;
  logic [31:0]       delay32, adv32, delay_adj, due;
  logic [31:0]       win_elapsed;
  logic              limit_en, restart, over;
  logic [7:0]        cnt_eff;
  logic              any_free;
  logic [SLOT_W-1:0] free_idx;
  sched_status_e     sched_st;
  logic [31:0]       fire_limit;
  logic              spacing_block, do_fire;
  logic              scan_hit;

  always_comb begin
    case (pos_q)
      2'd1:    dist_sel = dist1_q;
      2'd2:    dist_sel = dist2_q;
      2'd3:    dist_sel = dist3_q;
      default: dist_sel = '0;
    endcase
  end

  assign dividend = DIV_W'(DIV_W'(dist_sel) * MS_PER_S);

  dasch_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (speed_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_comb begin
    delay32     = 32'(quotient);
    adv32       = 32'(adv_q);
    delay_adj   = (delay32 > adv32) ? (delay32 - adv32) : '0;
    due         = time_q + delay_adj;
    win_elapsed = time_q - win_start_q;
    limit_en    = max_q != '0;
    restart     = (win_start_q == '0) || (win_elapsed >= WINDOW_MS);
    cnt_eff     = restart ? '0 : win_cnt_q;
    over        = cnt_eff >= max_q;
    any_free    = 1'b0;
    free_idx    = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!slot_valid_q[k]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(k);
      end
    end
    if (pos_q == 2'd0) begin
      sched_st = ST_PASS;
    end else if (dist_sel == '0) begin
      sched_st = ST_INVALID;
    end else if (limit_en && over) begin
      sched_st = ST_THROUGHPUT;
    end else if (!any_free) begin
      sched_st = ST_FULL;
    end else begin
      sched_st = ST_ACCEPTED;
    end
  end

  always_comb begin
    fire_limit    = last_fire_q + 32'(min_sp_q);
    spacing_block = (min_sp_q != '0) && (last_fire_q != '0) && (time_q < fire_limit);
    do_fire       = best_found_q && !spacing_block;
    scan_hit      = slot_valid_q[scan_idx_q] && (slot_due_q[scan_idx_q] <= time_q) &&
                    (!best_found_q || (slot_due_q[scan_idx_q] < best_due_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sp_q     <= '0;
      max_q        <= '0;
      speed_q      <= 16'd100;
      dist1_q      <= 16'd100;
      dist2_q      <= 16'd200;
      dist3_q      <= 16'd300;
      adv_q        <= '0;
      slot_valid_q <= '0;
      last_fire_q  <= '0;
      last_due_q   <= '0;
      win_start_q  <= '0;
      win_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MIN_SPACING:    min_sp_q <= cfg_data_i;
          CFG_MAX_PER_MINUTE: max_q    <= cfg_data_i[7:0];
          CFG_BELT_SPEED: begin
            if (cfg_data_i != '0) begin
              speed_q <= cfg_data_i;
            end
          end
          CFG_DIST_ONE:       dist1_q  <= cfg_data_i;
          CFG_DIST_TWO:       dist2_q  <= cfg_data_i;
          CFG_DIST_THREE:     dist3_q  <= cfg_data_i;
          CFG_ADVANCE:        adv_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.sched_commit) begin
        if ((pos_q != 2'd0) && (dist_sel != '0) && limit_en) begin
          if (restart) begin
            win_start_q <= time_q;
          end
          win_cnt_q <= over ? cnt_eff : cnt_eff + 8'd1;
        end
        if (sched_st == ST_ACCEPTED) begin
          slot_valid_q[free_idx] <= 1'b1;
          last_due_q             <= due;
        end
      end
      if (cmd_i.tick_commit && do_fire) begin
        slot_valid_q[best_idx_q] <= 1'b0;
        last_fire_q              <= time_q;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      time_q       <= time_ms_i;
      pos_q        <= target_pos_i;
      evt_q        <= event_id_i;
      scan_idx_q   <= '0;
      best_found_q <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      scan_idx_q <= scan_idx_q + 1'b1;
      if (scan_hit) begin
        best_found_q <= 1'b1;
        best_idx_q   <= scan_idx_q;
        best_due_q   <= slot_due_q[scan_idx_q];
        best_tgt_q   <= slot_tgt_q[scan_idx_q];
        best_evt_q   <= slot_evt_q[scan_idx_q];
      end
    end
    if (cmd_i.sched_commit) begin
      if (sched_st == ST_ACCEPTED) begin
        slot_due_q[free_idx] <= due;
        slot_tgt_q[free_idx] <= pos_q;
        slot_evt_q[free_idx] <= evt_q;
      end
      res_status_q <= sched_st;
      res_due_q    <= (sched_st == ST_ACCEPTED) ? due : '0;
      res_last_q   <= (sched_st == ST_ACCEPTED) ? due : last_due_q;
      res_fired_q  <= 1'b0;
      res_pos_q    <= '0;
      res_evt_q    <= '0;
    end
    if (cmd_i.tick_commit) begin
      res_status_q <= ST_ACCEPTED;
      res_due_q    <= '0;
      res_last_q   <= last_due_q;
      res_fired_q  <= do_fire;
      res_pos_q    <= do_fire ? best_tgt_q : '0;
      res_evt_q    <= do_fire ? best_evt_q : '0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_due_q    <= res_due_q;
      out_last_q   <= res_last_q;
      out_fired_q  <= res_fired_q;
      out_pos_q    <= res_pos_q;
      out_evt_q    <= res_evt_q;
    end
  end

  assign status_o.in_op     = operation_i;
  assign status_o.div_busy  = div_busy;
  assign status_o.scan_last = scan_idx_q == SLOT_W'(SLOTS - 1);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign sched_status_o   = out_status_q;
  assign due_ms_o         = out_due_q;
  assign fired_o          = out_fired_q;
  assign fired_pos_o      = out_pos_q;
  assign fired_event_id_o = out_evt_q;
  assign last_due_out_o   = out_last_q;

endmodule

// ----- rtl/core/dasch_ctrl.sv -----
module dasch_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dasch_pkg::dp_status_t status_i,
  output dasch_pkg::ctrl_cmd_t  cmd_o
);
  import dasch_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVST,
    S_DIV,
    S_SCHED,
    S_SCAN,
    S_TICK,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (status_i.in_op == OP_TICK) ? S_SCAN : S_DIVST;
        end
      end
      S_DIVST: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          state_d = S_SCHED;
        end
      end
      S_SCHED: begin
        cmd_o.sched_commit = 1'b1;
        state_d = S_OUT;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_TICK;
        end
      end
      S_TICK: begin
        cmd_o.tick_commit = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

// ----- rtl/core/diverter_actuation_scheduler.sv -----
// A schedule item runs through the restoring divider, one quotient bit per cycle over
// 26 bits, then its commit; a tick runs through the slot scan, one slot per cycle, then
// its commit. Both then wait in the output state until the output register is free; the
// next input transfer is taken in the cycle after the result is loaded.
// Reset (rst_ni low, asynchronous) clears all slots, timers, window count and output
// valid, and loads configuration defaults.
module diverter_actuation_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dasch_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dasch_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [31:0]                     time_ms_i,
  input  logic [1:0]                      target_pos_i,
  input  logic [15:0]                     event_id_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      sched_status_o,
  output logic [31:0]                     due_ms_o,
  output logic                            fired_o,
  output logic [1:0]                      fired_pos_o,
  output logic [15:0]                     fired_event_id_o,
  output logic [31:0]                     last_due_out_o
);
  import dasch_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  dasch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dasch_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .time_ms_i        (time_ms_i),
    .target_pos_i     (target_pos_i),
    .event_id_i       (event_id_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sched_status_o   (sched_status_o),
    .due_ms_o         (due_ms_o),
    .fired_o          (fired_o),
    .fired_pos_o      (fired_pos_o),
    .fired_event_id_o (fired_event_id_o),
    .last_due_out_o   (last_due_out_o)
  );

endmodule
